// ----- hdl/traffic_light_with_override_core_assert.svh -----
// ----------------------------------------------------------------------------
// traffic_light_with_override_core assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRAFFIC_LIGHT_WITH_OVERRIDE_CORE_ASSERT_SVH
`define TRAFFIC_LIGHT_WITH_OVERRIDE_CORE_ASSERT_SVH

// same-cycle implication
`define TLO_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tlo assertion failed");

// next-cycle implication
`define TLO_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tlo assertion failed");

`endif

// ----- hdl/tlo_pkg.sv -----
// ----------------------------------------------------------------------------
// tlo_pkg
// Types, constants and helpers for the traffic light with override.
// ----------------------------------------------------------------------------
package tlo_pkg;

	localparam int SecW  = 7;
	localparam int TickW = 8;
	localparam int SegW  = 8;

	localparam logic [SecW-1:0] SecMax = 7'd99;

	// register indexes
	typedef enum logic [1:0] {
		REG_PASS_SECONDS     = 2'd0,
		REG_AMBER_SECS       = 2'd1,
		REG_TICKS_PER_SECOND = 2'd2,
		REG_PINS_INVERTED    = 2'd3
	} reg_index_t;

	// lamp group / forced key; LT_NONE only means "not forced"
	typedef enum logic [1:0] {
		LT_NONE   = 2'd0,
		LT_HORIZ  = 2'd1,
		LT_YELLOW = 2'd2,
		LT_VERT   = 2'd3
	} light_t;

	typedef logic [SegW-1:0] seg_rom_t [10];

	localparam seg_rom_t SegCode = '{
		8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6
	};

	typedef struct packed {
		logic switch_horizontal;
		logic switch_yellow;
		logic switch_vertical;
		logic tick;
	} item_t;

	typedef struct packed {
		logic            lamp_horizontal;
		logic            lamp_yellow;
		logic            lamp_vertical;
		logic [SecW-1:0] seconds_left;
		logic [SegW-1:0] segment_tens;
		logic [SegW-1:0] segment_units;
		logic            display_update;
	} result_t;

	typedef struct packed {
		logic [SecW-1:0]  pass_seconds;
		logic [SecW-1:0]  amber_secs;
		logic [TickW-1:0] ticks_per_second;
		logic             pins_inverted;
	} cfg_t;

	typedef struct packed {
		light_t           phase;
		light_t           after_yellow;
		light_t           saved_phase;
		light_t           saved_after_yellow;
		light_t           forced_key;
		logic [SecW-1:0]  seconds;
		logic [TickW-1:0] tick_count;
	} state_t;

	localparam cfg_t CfgReset = '{
		pass_seconds:     7'd10,
		amber_secs:       7'd5,
		ticks_per_second: 8'd100,
		pins_inverted:    1'b1
	};

	localparam state_t StateReset = '{
		phase:              LT_HORIZ,
		after_yellow:       LT_VERT,
		saved_phase:        LT_HORIZ,
		saved_after_yellow: LT_VERT,
		forced_key:         LT_NONE,
		seconds:            7'd10,
		tick_count:         8'd0
	};

	function automatic logic [SecW-1:0] sat99(input logic [SecW-1:0] v);
		return (v > SecMax) ? SecMax : v;
	endfunction

	// tens digit of n <= 99 via reciprocal multiply (205/2048)
	function automatic logic [3:0] tens_of(input logic [SecW-1:0] n);
		logic [14:0] p;
		p = {8'd0, n} * 15'd205;
		return p[14:11];
	endfunction

	function automatic logic [3:0] units_of(input logic [SecW-1:0] n);
		logic [SecW-1:0] t10;
		logic [SecW-1:0] u;
		t10 = {3'd0, tens_of(n)} * 7'd10;
		u   = n - t10;
		return u[3:0];
	endfunction

endpackage

// ----- hdl/tlo_step.sv -----
// ----------------------------------------------------------------------------
// tlo_step
// Per-item state update and result formatting, purely combinational.
// ----------------------------------------------------------------------------
module tlo_step import tlo_pkg::*; (
	input  cfg_t    cfg,
	input  state_t  cur,
	input  item_t   item,
	output state_t  nxt,
	output result_t result
);

	logic             on_h;
	logic             on_y;
	logic             on_v;
	light_t           key;
	logic [TickW-1:0] tick_inc;
	logic             update;
	logic [3:0]       tens;
	logic [3:0]       units;

	assign on_h = item.switch_horizontal ^ cfg.pins_inverted;
	assign on_y = item.switch_yellow     ^ cfg.pins_inverted;
	assign on_v = item.switch_vertical   ^ cfg.pins_inverted;

	always_comb begin
		key = LT_NONE;
		if (on_h && !on_y && !on_v) begin
			key = LT_HORIZ;
		end else if (on_y && !on_h && !on_v) begin
			key = LT_YELLOW;
		end else if (on_v && !on_h && !on_y) begin
			key = LT_VERT;
		end
	end

	assign tick_inc = cur.tick_count + 8'd1;

	// next state
	always_comb begin
		nxt    = cur;
		update = 1'b0;
		if (key != LT_NONE) begin
			if (cur.forced_key == LT_NONE) begin
				nxt.saved_phase        = cur.phase;
				nxt.saved_after_yellow = cur.after_yellow;
				nxt.forced_key         = key;
				nxt.tick_count         = '0;
				nxt.phase              = key;
				update                 = 1'b1;
			end else if (key != cur.forced_key) begin
				nxt.forced_key = key;
				nxt.phase      = key;
				update         = 1'b1;
			end
		end else if (cur.forced_key != LT_NONE) begin
			nxt.phase        = cur.saved_phase;
			nxt.after_yellow = cur.saved_after_yellow;
			nxt.forced_key   = LT_NONE;
			nxt.tick_count   = '0;
			update           = 1'b1;
		end else if (item.tick) begin
			if (tick_inc >= cfg.ticks_per_second) begin
				nxt.tick_count = '0;
				update         = 1'b1;
				if (cur.seconds == '0) begin
					case (cur.phase)
						LT_HORIZ: begin
							nxt.after_yellow = LT_VERT;
							nxt.phase        = LT_YELLOW;
							nxt.seconds      = cfg.amber_secs;
						end
						LT_VERT: begin
							nxt.after_yellow = LT_HORIZ;
							nxt.phase        = LT_YELLOW;
							nxt.seconds      = cfg.amber_secs;
						end
						default: begin
							nxt.phase   = (cur.after_yellow == LT_HORIZ) ? LT_HORIZ : LT_VERT;
							nxt.seconds = cfg.pass_seconds;
						end
					endcase
				end else begin
					nxt.seconds = cur.seconds - 7'd1;
				end
			end else begin
				nxt.tick_count = tick_inc;
			end
		end
	end

	// outputs
	always_comb begin
		tens                   = tens_of(nxt.seconds);
		units                  = units_of(nxt.seconds);
		result.lamp_horizontal = (nxt.phase == LT_HORIZ);
		result.lamp_yellow     = (nxt.phase == LT_YELLOW);
		result.lamp_vertical   = (nxt.phase != LT_HORIZ) && (nxt.phase != LT_YELLOW);
		result.seconds_left    = nxt.seconds;
		result.segment_tens    = SegCode[tens];
		result.segment_units   = SegCode[units];
		result.display_update  = update;
	end

endmodule

// ----- hdl/traffic_light_with_override_core.sv -----
// Each item passes the input register (item_s1), then the result register (result_q).
// Throughput: one item per cycle unless output stalls; single pass of short logic.
// A stalled result register holds one result and still lets one item wait in stage 1.
// Reset (arst_n low, async): state, config, valids default; horizontal pass, countdown 10.
// No clearing pass; the block accepts items from the first cycle after reset.
// ----------------------------------------------------------------------------
// traffic_light_with_override_core
// Traffic light controller with switch override, one result per input beat.
// ----------------------------------------------------------------------------
module traffic_light_with_override_core import tlo_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  item_t            item,
	output logic             result_valid,
	input  logic             result_ready,
	output result_t          result,
	input  logic             cfg_wr_en,
	input  reg_index_t       cfg_index,
	input  logic [TickW-1:0] cfg_wdata
);

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	item_t   item_s1;
	logic    valid_s1;
	result_t result_nxt;
	result_t result_q;
	logic    result_valid_q;
	logic    advance;

	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CfgReset;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PASS_SECONDS:     cfg_q.pass_seconds     <= sat99(cfg_wdata[SecW-1:0]);
				REG_AMBER_SECS:       cfg_q.amber_secs       <= sat99(cfg_wdata[SecW-1:0]);
				REG_TICKS_PER_SECOND: cfg_q.ticks_per_second <= cfg_wdata;
				REG_PINS_INVERTED:    cfg_q.pins_inverted    <= cfg_wdata[0];
				default:              cfg_q <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	tlo_step u_step (
		.cfg    (cfg_q),
		.cur    (state_q),
		.item   (item_s1),
		.nxt    (state_nxt),
		.result (result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= StateReset;
			result_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`include "traffic_light_with_override_core_assert.svh"

	`TLO_ASSERT_NOW(a_lamp_onehot, result_valid_q,
		$onehot({result_q.lamp_horizontal, result_q.lamp_yellow, result_q.lamp_vertical}))
	`TLO_ASSERT_NOW(a_seconds_range, 1'b1, state_q.seconds <= SecMax)
	`TLO_ASSERT_NOW(a_forced_no_ticks, state_q.forced_key != LT_NONE,
		state_q.tick_count == '0 && state_q.phase == state_q.forced_key)
	`TLO_ASSERT_NEXT(a_advance_gives_result, advance, result_valid_q)

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: traffic_light_with_override_core testbench
// Sends switch and tick beats with random gaps and stalls. A built-in model of
// the light sequence and the override predicts each result, and each result
// is checked field by field, in order. Registers change between phases.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tlo_pkg::*;

	localparam int unsigned CycleLimit = 400000;
	localparam logic [7:0] DigitSeg [10] = '{
		8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6
	};

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             item_valid   = 1'b0;
	logic             item_ready;
	item_t            item         = '0;
	logic             result_valid;
	logic             result_ready = 1'b0;
	result_t          result;
	logic             cfg_wr_en    = 1'b0;
	reg_index_t       cfg_index    = REG_PASS_SECONDS;
	logic [TickW-1:0] cfg_wdata    = '0;

	// light model: registers and state
	logic [6:0] pass_len;
	logic [6:0] yellow_len;
	logic [7:0] tick_div;
	logic       act_low;
	light_t     ph;
	light_t     after_y;
	light_t     saved_ph;
	light_t     saved_after_y;
	light_t     forced;
	logic [6:0] secs;
	logic [7:0] ticks;

	item_t       items_to_send[$];
	result_t     lights_due[$];
	int unsigned items_queued   = 0;
	int unsigned items_accepted = 0;
	int unsigned fail_count     = 0;
	int unsigned cycle_count    = 0;

	logic    item_taken   = 1'b0;
	logic    res_taken    = 1'b0;
	int      send_wait    = 0;
	int      recv_wait    = 0;
	int      send_draw;
	int      recv_draw;
	bit      steady_send  = 1'b0;
	bit      steady_recv  = 1'b0;
	result_t head;

	traffic_light_with_override_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	function automatic int draw_gap(bit steady);
		if (steady || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 13);
	endfunction

	function automatic result_t advance_light(item_t it);
		logic    h;
		logic    y;
		logic    v;
		light_t  key;
		logic    upd;
		logic [6:0] n;
		result_t r;
		h = it.switch_horizontal ^ act_low;
		y = it.switch_yellow ^ act_low;
		v = it.switch_vertical ^ act_low;
		key = LT_NONE;
		upd = 1'b0;
		if (h && !y && !v) key = LT_HORIZ;
		else if (y && !h && !v) key = LT_YELLOW;
		else if (v && !h && !y) key = LT_VERT;

		if (key != LT_NONE) begin
			if (forced == LT_NONE) begin
				saved_ph = ph;
				saved_after_y = after_y;
				forced = key;
				ticks = '0;
				ph = key;
				upd = 1'b1;
			end else if (key != forced) begin
				forced = key;
				ph = key;
				upd = 1'b1;
			end
		end else if (forced != LT_NONE) begin
			ph = saved_ph;
			after_y = saved_after_y;
			forced = LT_NONE;
			ticks = '0;
			upd = 1'b1;
		end else if (it.tick) begin
			ticks = ticks + 8'd1;
			if (ticks >= tick_div) begin
				ticks = '0;
				upd = 1'b1;
				if (secs == 0) begin
					if (ph == LT_HORIZ) begin
						after_y = LT_VERT;
						ph = LT_YELLOW;
						secs = yellow_len;
					end else if (ph == LT_VERT) begin
						after_y = LT_HORIZ;
						ph = LT_YELLOW;
						secs = yellow_len;
					end else begin
						ph = (after_y == LT_HORIZ) ? LT_HORIZ : LT_VERT;
						secs = pass_len;
					end
				end else begin
					secs = secs - 7'd1;
				end
			end
		end

		n = (secs > 7'd99) ? 7'd99 : secs;
		r.lamp_horizontal = (ph == LT_HORIZ);
		r.lamp_yellow     = (ph == LT_YELLOW);
		r.lamp_vertical   = (ph != LT_HORIZ && ph != LT_YELLOW);
		r.seconds_left    = n;
		r.segment_tens    = DigitSeg[n / 10];
		r.segment_units   = DigitSeg[n % 10];
		r.display_update  = upd;
		return r;
	endfunction

	task automatic check_field(string fname, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, fname, want, got);
			fail_count++;
		end
	endtask

	// sender: holds each beat until taken, then waits its drawn gap
	always @(negedge clk) begin
		if (arst_n) begin
			if (item_valid && item_taken) begin
				send_draw = draw_gap(steady_send);
				if (send_draw == 0 && items_to_send.size() != 0) begin
					item <= items_to_send.pop_front();
				end else begin
					item_valid <= 1'b0;
					send_wait <= send_draw;
				end
			end else if (!item_valid) begin
				if (send_wait > 0) begin
					send_wait <= send_wait - 1;
				end else if (items_to_send.size() != 0) begin
					item <= items_to_send.pop_front();
					item_valid <= 1'b1;
				end
			end
		end
	end

	// receiver: may stall for a drawn gap after each result beat
	always @(negedge clk) begin
		if (arst_n) begin
			if (res_taken) begin
				recv_draw = draw_gap(steady_recv);
				recv_wait <= recv_draw;
				result_ready <= (recv_draw == 0);
			end else if (recv_wait > 0) begin
				recv_wait <= recv_wait - 1;
				result_ready <= (recv_wait == 1);
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			item_taken <= item_valid && item_ready;
			res_taken <= result_valid && result_ready;
			if (result_valid && result_ready) begin
				if (lights_due.size() == 0) begin
					$display("%0t: unexpected result beat, expected none actual %h",
						$time, result);
					fail_count++;
				end else begin
					head = lights_due.pop_front();
					check_field("lamp_horizontal", head.lamp_horizontal,
						result.lamp_horizontal);
					check_field("lamp_yellow", head.lamp_yellow, result.lamp_yellow);
					check_field("lamp_vertical", head.lamp_vertical, result.lamp_vertical);
					check_field("seconds_left", head.seconds_left, result.seconds_left);
					check_field("segment_tens", head.segment_tens, result.segment_tens);
					check_field("segment_units", head.segment_units, result.segment_units);
					check_field("display_update", head.display_update,
						result.display_update);
				end
			end
			if (item_valid && item_ready) begin
				lights_due.push_back(advance_light(item));
				items_accepted++;
			end
		end
	end

	task automatic push_pins(logic [3:0] pins);
		items_to_send.push_back(item_t'(pins));
		items_queued++;
	endtask

	// switch states given as on/off, mapped to pin levels by polarity
	task automatic push_on(bit h, bit y, bit v, bit t);
		push_pins({h ^ act_low, y ^ act_low, v ^ act_low, t});
	endtask

	task automatic write_reg(reg_index_t idx, logic [7:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_PASS_SECONDS: begin
				pass_len = (val[6:0] > 7'd99) ? 7'd99 : val[6:0];
			end
			REG_AMBER_SECS: begin
				yellow_len = (val[6:0] > 7'd99) ? 7'd99 : val[6:0];
			end
			REG_TICKS_PER_SECOND: tick_div = val;
			REG_PINS_INVERTED: act_low = val[0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (items_accepted != items_queued || lights_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// mostly normal running with override episodes, plus raw pin noise
	task automatic add_traffic(int count);
		int     n;
		int     run;
		light_t k;
		n = 0;
		while (n < count) begin
			case ($urandom_range(0, 9))
				0: begin
					push_pins(4'($urandom_range(0, 15)));
					n++;
				end
				1, 2: begin
					run = $urandom_range(1, 6);
					k = light_t'($urandom_range(1, 3));
					repeat (run) begin
						if ($urandom_range(0, 3) == 0)
							k = light_t'($urandom_range(1, 3));
						push_on(k == LT_HORIZ, k == LT_YELLOW, k == LT_VERT,
							1'($urandom_range(0, 1)));
						n++;
					end
					push_on(1'b0, 1'b0, 1'b0, 1'($urandom_range(0, 1)));
					n++;
				end
				default: begin
					push_on(1'b0, 1'b0, 1'b0, $urandom_range(0, 3) != 0);
					n++;
				end
			endcase
		end
	endtask

	task automatic run_phase(logic [7:0] p, logic [7:0] y, logic [7:0] t, bit al,
			int count, bit steady);
		write_reg(REG_PASS_SECONDS, p);
		write_reg(REG_AMBER_SECS, y);
		write_reg(REG_TICKS_PER_SECOND, t);
		write_reg(REG_PINS_INVERTED, {7'd0, al});
		steady_send = steady && $urandom_range(0, 1);
		steady_recv = steady;
		add_traffic(count);
		drain();
	endtask

	initial begin
		wait (cycle_count >= CycleLimit);
		$display("traffic_light_with_override_core verification failed");
		$finish;
	end

	initial begin
		pass_len = 7'd10;
		yellow_len = 7'd5;
		tick_div = 8'd100;
		act_low = 1'b1;
		ph = LT_HORIZ;
		after_y = LT_VERT;
		saved_ph = LT_HORIZ;
		saved_after_y = LT_VERT;
		forced = LT_NONE;
		secs = 7'd10;
		ticks = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// defaults: idle, tick, each override, key change, multiple switches
		push_on(1'b0, 1'b0, 1'b0, 1'b0);
		push_on(1'b0, 1'b0, 1'b0, 1'b1);
		push_on(1'b1, 1'b0, 1'b0, 1'b1);
		push_on(1'b0, 1'b1, 1'b0, 1'b1);
		push_on(1'b0, 1'b0, 1'b1, 1'b0);
		push_on(1'b1, 1'b0, 1'b1, 1'b1);
		push_on(1'b1, 1'b1, 1'b1, 1'b1);
		push_on(1'b0, 1'b0, 1'b0, 1'b1);
		push_pins(4'h0);
		push_pins(4'hF);
		drain();

		// every tick a second, active-high switches
		write_reg(REG_PASS_SECONDS, 8'd1);
		write_reg(REG_AMBER_SECS, 8'd0);
		write_reg(REG_TICKS_PER_SECOND, 8'd0);
		write_reg(REG_PINS_INVERTED, 8'd0);
		repeat (3) push_on(1'b0, 1'b0, 1'b0, 1'b1);
		push_on(1'b0, 1'b1, 1'b0, 1'b1);
		push_on(1'b0, 1'b0, 1'b0, 1'b1);
		repeat (2) push_on(1'b0, 1'b0, 1'b0, 1'b1);
		drain();

		// divider lowered below the running tick count
		write_reg(REG_TICKS_PER_SECOND, 8'd4);
		repeat (3) push_on(1'b0, 1'b0, 1'b0, 1'b1);
		drain();
		write_reg(REG_TICKS_PER_SECOND, 8'd1);
		write_reg(REG_PASS_SECONDS, 8'd127);
		write_reg(REG_AMBER_SECS, 8'd250);
		push_on(1'b0, 1'b0, 1'b0, 1'b1);
		drain();

		run_phase(8'd3, 8'd2, 8'd1, 1'b0, 150, 1'b0);
		run_phase(8'd0, 8'd0, 8'd0, 1'b1, 120, 1'b1);
		run_phase(8'd127, 8'd99, 8'd255, 1'b0, 60, 1'b0);
		run_phase(8'd200, 8'd1, 8'd2, 1'b1, 120, 1'b0);
		repeat (5) begin
			run_phase(8'($urandom_range(0, 6)), 8'($urandom_range(0, 4)),
				8'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 110,
				$urandom_range(0, 3) == 0);
		end

		repeat (6) @(negedge clk);
		if (fail_count == 0) begin
			$display("traffic_light_with_override_core verification clean");
		end else begin
			$display("traffic_light_with_override_core verification failed");
		end
		$finish;
	end

endmodule
